@@ rtl/core/att_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_pkg
// Shared sizes, codes and record layout of the allocation tracking table.
// ----------------------------------------------------------------------------
package att_pkg;

  // BUCKETS must be a power of two: the bucket is the low address bits.
  localparam int unsigned BUCKETS      = 1024;
  localparam int unsigned POOL_RECORDS = 16384;
  localparam int unsigned ADDR_BITS    = 48;

  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned SLOT_W = $clog2(POOL_RECORDS);
  localparam int unsigned LINK_W = SLOT_W + 1;
  localparam int unsigned CNT_W  = SLOT_W + 1;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned BYTES_W  = 31;
  localparam int unsigned LINE_W   = 24;
  localparam int unsigned FILE_W   = 16;
  localparam int unsigned SITE_W   = LINE_W + FILE_W;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIVE_W   = 15;
  localparam int unsigned BKTNUM_W = 10;

  // Record body: {address, kind, bytes, site}
  localparam int unsigned BODY_W = ADDR_BITS + 1 + BYTES_W + SITE_W;
  // Bucket entry: {head, tail}
  localparam int unsigned HT_W = 2 * LINK_W;

  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(POOL_RECORDS);

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_REALLOC = 2'd1,
    OP_FREE    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_RECORDED = 3'd0,
    ST_RELEASED = 3'd1,
    ST_FULL     = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

endpackage

@@ rtl/core/att_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_if
// Handshake channels of the allocation tracking table: item, result, config.
// ----------------------------------------------------------------------------
interface att_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [att_pkg::OPCODE_W-1:0]          opcode;
  logic [47:0]                           address;
  logic [att_pkg::BYTES_W-1:0]           alloc_size;
  logic [att_pkg::LINE_W-1:0]            source_line;
  logic [att_pkg::FILE_W-1:0]            source_file_id;

  modport source (output valid, opcode, address, alloc_size, source_line, source_file_id,
                  input ready);
  modport sink (input valid, opcode, address, alloc_size, source_line, source_file_id,
                output ready);
endinterface

interface att_out_if;
  logic                          valid;
  logic                          ready;
  logic [att_pkg::STATUS_W-1:0]  status;
  logic [att_pkg::LIVE_W-1:0]    live_count;
  logic [att_pkg::BKTNUM_W-1:0]  bucket_number;

  modport source (output valid, status, live_count, bucket_number, input ready);
  modport sink (input valid, status, live_count, bucket_number, output ready);
endinterface

interface att_cfg_if;
  logic valid;
  logic ready;
  logic tracking_enabled;

  modport source (output valid, tracking_enabled, input ready);
  modport sink (input valid, tracking_enabled, output ready);
endinterface

@@ rtl/core/att_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module att_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/allocation_tracking_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_tracking_table_core
// Hash-chained table of live allocations kept in synchronous RAMs.
// ----------------------------------------------------------------------------
// Flow: disabled, full or undefined items go from S_IDLE straight to S_FIN;
//   alloc/realloc via S_ALLOC, S_ALINK; release via S_FHEAD, S_FWALK per record.
// Throughput: one item at a time; the next item is taken as soon as the
//   sequencer is idle, even while the previous result waits on the output.
// Reset: a clearing pass over all BUCKETS (1024) entries empties the bucket RAM;
//   no item is taken meanwhile. Config beats are taken at any time.
// ----------------------------------------------------------------------------
module allocation_tracking_table_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  att_in_if.sink  in_i,
  att_out_if.source out_o,
  att_cfg_if.sink cfg_i
);

  localparam int unsigned BKT_W  = att_pkg::BKT_W;
  localparam int unsigned SLOT_W = att_pkg::SLOT_W;
  localparam int unsigned LINK_W = att_pkg::LINK_W;
  localparam int unsigned CNT_W  = att_pkg::CNT_W;
  localparam int unsigned AB     = att_pkg::ADDR_BITS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,   // slot and bucket tail arrive; write the new record
    S_ALINK,   // chain the old tail to the new record
    S_FHEAD,   // bucket head arrives; start the walk
    S_FWALK,   // compare one record per cycle; unlink on match
    S_FIN      // wait for the output register
  } state_e;

  state_e                        st_q;
  logic                          en_q;
  logic [BKT_W-1:0]              clr_q;
  logic [CNT_W-1:0]              held_q;
  logic [CNT_W-1:0]              hw_q;     // highest count ever held
  logic [AB-1:0]                 addr_q;
  logic                          kind_q;
  logic [att_pkg::BYTES_W-1:0]   bytes_q;
  logic [att_pkg::SITE_W-1:0]    site_q;
  att_pkg::status_e              status_q;
  logic [SLOT_W-1:0]             slot_q;
  logic [LINK_W-1:0]             tail_q;
  logic [LINK_W-1:0]             cur_q;
  logic [att_pkg::HT_W-1:0]      ht_q;

  logic                          out_valid_q;
  logic [att_pkg::STATUS_W-1:0]  out_status_q;
  logic [att_pkg::LIVE_W-1:0]    out_live_q;
  logic [att_pkg::BKTNUM_W-1:0]  out_bkt_q;

  // RAM ports
  logic                          ht_we, ht_re;
  logic [BKT_W-1:0]              ht_waddr, ht_raddr;
  logic [att_pkg::HT_W-1:0]      ht_wdata, ht_rdata;
  logic                          nx_we, pv_we, bd_we, rec_re;
  logic [SLOT_W-1:0]             nx_waddr, pv_waddr, rec_raddr;
  logic [LINK_W-1:0]             nx_wdata, pv_wdata, nx_rdata, pv_rdata;
  logic [att_pkg::BODY_W-1:0]    bd_wdata, bd_rdata;
  logic                          sk_we, sk_re;
  logic [SLOT_W-1:0]             sk_waddr, sk_raddr, sk_wdata, sk_rdata;

  logic                          in_acc;
  logic [BKT_W-1:0]              bkt_q;
  logic [SLOT_W-1:0]             new_slot;
  logic [LINK_W-1:0]             bkt_head, bkt_tail;
  logic [LINK_W-1:0]             walk_p, walk_n;
  logic                          walk_hit;
  logic [CNT_W-1:0]              held_dec;
  logic                          out_free;

  assign in_i.ready  = (st_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign bkt_head = ht_rdata[2*LINK_W-1:LINK_W];
  assign bkt_tail = ht_rdata[LINK_W-1:0];
  // untouched stack entries hold their own fill level, so skip the RAM there
  assign new_slot = (hw_q > held_q) ? sk_rdata : held_q[SLOT_W-1:0];
  assign walk_hit = (bd_rdata[att_pkg::BODY_W-1 -: AB] == addr_q);
  assign walk_p   = pv_rdata;
  assign walk_n   = nx_rdata;
  assign held_dec = held_q - CNT_W'(1);

  // RAM control: reads issued on accept / walk steps, writes on commit and clear
  always_comb begin
    ht_we     = 1'b0;
    ht_waddr  = bkt_q;
    ht_wdata  = ht_q;
    ht_re     = 1'b0;
    ht_raddr  = in_i.address[BKT_W-1:0];
    nx_we     = 1'b0;
    nx_waddr  = new_slot;
    nx_wdata  = att_pkg::NO_LINK;
    pv_we     = 1'b0;
    pv_waddr  = new_slot;
    pv_wdata  = bkt_tail;
    bd_we     = 1'b0;
    bd_wdata  = {addr_q, kind_q, bytes_q, site_q};
    rec_re    = 1'b0;
    rec_raddr = bkt_head[SLOT_W-1:0];
    sk_we     = 1'b0;
    sk_waddr  = SLOT_W'(att_pkg::POOL_RECORDS - 1) - held_dec[SLOT_W-1:0];
    sk_wdata  = cur_q[SLOT_W-1:0];
    sk_re     = 1'b0;
    sk_raddr  = SLOT_W'(att_pkg::POOL_RECORDS - 1) - held_q[SLOT_W-1:0];
    case (st_q)
      S_CLEAR: begin
        ht_we    = 1'b1;
        ht_waddr = clr_q;
        ht_wdata = {att_pkg::NO_LINK, att_pkg::NO_LINK};
      end
      S_IDLE: begin
        ht_re = in_acc;
        sk_re = in_acc;
      end
      S_ALLOC: begin
        bd_we    = 1'b1;
        nx_we    = 1'b1;
        pv_we    = 1'b1;
        ht_we    = 1'b1;
        ht_wdata = {(bkt_head == att_pkg::NO_LINK) ? {1'b0, new_slot} : bkt_head,
                    {1'b0, new_slot}};
      end
      S_ALINK: begin
        nx_we    = (tail_q != att_pkg::NO_LINK);
        nx_waddr = tail_q[SLOT_W-1:0];
        nx_wdata = {1'b0, slot_q};
      end
      S_FHEAD: begin
        rec_re = (bkt_head != att_pkg::NO_LINK);
      end
      S_FWALK: begin
        if (walk_hit) begin
          nx_we    = (walk_p != att_pkg::NO_LINK);
          nx_waddr = walk_p[SLOT_W-1:0];
          nx_wdata = walk_n;
          pv_we    = (walk_n != att_pkg::NO_LINK);
          pv_waddr = walk_n[SLOT_W-1:0];
          pv_wdata = walk_p;
          ht_we    = 1'b1;
          ht_wdata = {(walk_p == att_pkg::NO_LINK) ? walk_n : ht_q[2*LINK_W-1:LINK_W],
                      (walk_n == att_pkg::NO_LINK) ? walk_p : ht_q[LINK_W-1:0]};
          sk_we    = 1'b1;
        end else begin
          rec_re    = (walk_n != att_pkg::NO_LINK);
          rec_raddr = walk_n[SLOT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      en_q        <= 1'b0;
      clr_q       <= '0;
      held_q      <= '0;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        en_q <= cfg_i.tracking_enabled;
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_CLEAR: begin
          clr_q <= clr_q + BKT_W'(1);
          if (clr_q == BKT_W'(att_pkg::BUCKETS - 1)) begin
            st_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            addr_q  <= in_i.address[AB-1:0];
            bkt_q   <= in_i.address[BKT_W-1:0];
            kind_q  <= (in_i.opcode == att_pkg::OP_REALLOC);
            bytes_q <= in_i.alloc_size;
            site_q  <= {in_i.source_line, in_i.source_file_id};
            if (!en_q) begin
              status_q <= att_pkg::ST_IGNORED;
              st_q     <= S_FIN;
            end else if (in_i.opcode == att_pkg::OP_ALLOC ||
                         in_i.opcode == att_pkg::OP_REALLOC) begin
              if (held_q == CNT_W'(att_pkg::POOL_RECORDS)) begin
                status_q <= att_pkg::ST_FULL;
                st_q     <= S_FIN;
              end else begin
                st_q <= S_ALLOC;
              end
            end else if (in_i.opcode == att_pkg::OP_FREE) begin
              st_q <= S_FHEAD;
            end else begin
              status_q <= att_pkg::ST_UNKNOWN;
              st_q     <= S_FIN;
            end
          end
        end
        S_ALLOC: begin
          slot_q   <= new_slot;
          tail_q   <= bkt_tail;
          held_q   <= held_q + CNT_W'(1);
          if (hw_q == held_q) begin
            hw_q <= held_q + CNT_W'(1);
          end
          status_q <= att_pkg::ST_RECORDED;
          st_q     <= S_ALINK;
        end
        S_ALINK: begin
          st_q <= S_FIN;
        end
        S_FHEAD: begin
          ht_q  <= ht_rdata;
          cur_q <= bkt_head;
          if (bkt_head == att_pkg::NO_LINK) begin
            status_q <= att_pkg::ST_UNKNOWN;
            st_q     <= S_FIN;
          end else begin
            st_q <= S_FWALK;
          end
        end
        S_FWALK: begin
          if (walk_hit) begin
            held_q   <= held_dec;
            status_q <= att_pkg::ST_RELEASED;
            st_q     <= S_FIN;
          end else if (walk_n == att_pkg::NO_LINK) begin
            status_q <= att_pkg::ST_UNKNOWN;
            st_q     <= S_FIN;
          end else begin
            cur_q <= walk_n;
          end
        end
        S_FIN: begin
          // load the result beat once the output register is free
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_live_q   <= att_pkg::LIVE_W'(held_q);
            out_bkt_q    <= att_pkg::BKTNUM_W'(bkt_q);
            st_q         <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.live_count    = out_live_q;
  assign out_o.bucket_number = out_bkt_q;

  att_ram #(.WIDTH(att_pkg::HT_W), .DEPTH(att_pkg::BUCKETS)) u_ht_ram (
    .clk_i, .we_i(ht_we), .waddr_i(ht_waddr), .wdata_i(ht_wdata),
    .re_i(ht_re), .raddr_i(ht_raddr), .rdata_o(ht_rdata)
  );

  att_ram #(.WIDTH(LINK_W), .DEPTH(att_pkg::POOL_RECORDS)) u_next_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .re_i(rec_re), .raddr_i(rec_raddr), .rdata_o(nx_rdata)
  );

  att_ram #(.WIDTH(LINK_W), .DEPTH(att_pkg::POOL_RECORDS)) u_prev_ram (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .re_i(rec_re), .raddr_i(rec_raddr), .rdata_o(pv_rdata)
  );

  att_ram #(.WIDTH(att_pkg::BODY_W), .DEPTH(att_pkg::POOL_RECORDS)) u_body_ram (
    .clk_i, .we_i(bd_we), .waddr_i(new_slot), .wdata_i(bd_wdata),
    .re_i(rec_re), .raddr_i(rec_raddr), .rdata_o(bd_rdata)
  );

  att_ram #(.WIDTH(SLOT_W), .DEPTH(att_pkg::POOL_RECORDS)) u_stack_ram (
    .clk_i, .we_i(sk_we), .waddr_i(sk_waddr), .wdata_i(sk_wdata),
    .re_i(sk_re), .raddr_i(sk_raddr), .rdata_o(sk_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_held_le_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= hw_q && hw_q <= CNT_W'(att_pkg::POOL_RECORDS))
    else $error("fill level above high-water mark or pool size");

  a_held_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q == S_ALLOC || (st_q == S_FWALK && walk_hit)) |=> $stable(held_q))
    else $error("record count changed outside a commit");

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_CLEAR |-> !in_i.ready)
    else $error("item taken during bucket clearing pass");

  a_fin_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIN && out_free) |=> out_valid_q && st_q == S_IDLE)
    else $error("finished item did not reach the output register");

endmodule

@@ dv/allocation_tracking_table_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_tracking_table_core_test
// Self-checking bench for the allocation tracking table. A scoreboard class
// keeps its own bucket chains and free stack. For every accepted item it
// predicts status, live count and bucket. Every result beat is checked in
// order. Stimulus covers a directed pass, random traffic under three idling
// mixes, and tracking being switched off and on.
// ----------------------------------------------------------------------------
module allocation_tracking_table_core_test;

  localparam int unsigned CYCLE_LIMIT = 1500000;

  localparam int unsigned POOL_RECORDS = att_pkg::POOL_RECORDS;
  localparam int unsigned BUCKETS      = att_pkg::BUCKETS;
  localparam int unsigned STATUS_W     = att_pkg::STATUS_W;
  localparam int unsigned LIVE_W       = att_pkg::LIVE_W;
  localparam int unsigned BKTNUM_W     = att_pkg::BKTNUM_W;
  localparam int unsigned BYTES_W      = att_pkg::BYTES_W;
  localparam int unsigned LINE_W       = att_pkg::LINE_W;
  localparam int unsigned FILE_W       = att_pkg::FILE_W;

  typedef struct packed {
    att_pkg::status_e      status;
    logic [LIVE_W-1:0]     live;
    logic [BKTNUM_W-1:0]   bucket;
  } verdict_t;

  // Scoreboard: shadow table plus the queue of verdicts still owed.
  class table_scoreboard;
    logic [47:0]  slot_addr [POOL_RECORDS];
    int unsigned  free_stack [POOL_RECORDS];
    int unsigned  chain [BUCKETS][$];
    int unsigned  held;
    bit           enabled;
    verdict_t     owed [$];
    int unsigned  errors;

    function void clear();
      for (int i = 0; i < POOL_RECORDS; i++) free_stack[i] = POOL_RECORDS - 1 - i;
      for (int b = 0; b < BUCKETS; b++) chain[b].delete();
      held = 0;
      enabled = 0;
      owed.delete();
      errors = 0;
    endfunction

    // Apply one accepted item to the shadow table and queue its verdict.
    function void note_item(att_pkg::opcode_e op, logic [47:0] addr);
      verdict_t    v;
      int unsigned bkt;
      int unsigned slot;
      int          hit;
      bkt = addr % BUCKETS;
      v.bucket = bkt[BKTNUM_W-1:0];
      if (!enabled) begin
        v.status = att_pkg::ST_IGNORED;
      end else if (op == att_pkg::OP_ALLOC || op == att_pkg::OP_REALLOC) begin
        if (held >= POOL_RECORDS) begin
          v.status = att_pkg::ST_FULL;
        end else begin
          slot = free_stack[POOL_RECORDS - 1 - held];
          held++;
          slot_addr[slot] = addr;
          chain[bkt].push_back(slot);
          v.status = att_pkg::ST_RECORDED;
        end
      end else if (op == att_pkg::OP_FREE) begin
        hit = -1;
        // Oldest record first: the chain queue keeps insertion order.
        foreach (chain[bkt][k]) begin
          if (hit < 0 && slot_addr[chain[bkt][k]] == addr) hit = k;
        end
        if (hit < 0) begin
          v.status = att_pkg::ST_UNKNOWN;
        end else begin
          slot = chain[bkt][hit];
          chain[bkt].delete(hit);
          held--;
          free_stack[POOL_RECORDS - 1 - held] = slot;
          v.status = att_pkg::ST_RELEASED;
        end
      end else begin
        v.status = att_pkg::ST_UNKNOWN;
      end
      v.live = held[LIVE_W-1:0];
      owed.push_back(v);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [LIVE_W-1:0] live,
                               logic [BKTNUM_W-1:0] bkt);
      verdict_t v;
      if (owed.size() == 0) begin
        $display("%0t: result beat with nothing owed: status %0d live %0d bucket %0d",
                 $time, st, live, bkt);
        errors++;
        return;
      end
      v = owed.pop_front();
      if (st !== v.status) begin
        $display("%0t: status expected %0d actual %0d", $time, v.status, st);
        errors++;
      end
      if (live !== v.live) begin
        $display("%0t: live_count expected %0d actual %0d", $time, v.live, live);
        errors++;
      end
      if (bkt !== v.bucket) begin
        $display("%0t: bucket_number expected %0d actual %0d", $time, v.bucket, bkt);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  att_in_if  in_ch ();
  att_out_if out_ch ();
  att_cfg_if cfg_ch ();

  allocation_tracking_table_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  table_scoreboard sb;
  int unsigned     cycles;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     hold_left;
  logic [47:0]     live_addrs [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort on runaway; the clearing pass and all traffic fit well inside.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      sb.note_item(att_pkg::opcode_e'(in_ch.opcode), in_ch.address);
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.status, out_ch.live_count, out_ch.bucket_number);
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drive one item beat and hold it until it is accepted.
  task automatic send_item(att_pkg::opcode_e op, logic [47:0] addr,
                           logic [BYTES_W-1:0] size,
                           logic [LINE_W-1:0] line, logic [FILE_W-1:0] file_id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.address        <= addr;
    in_ch.alloc_size     <= size;
    in_ch.source_line    <= line;
    in_ch.source_file_id <= file_id;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_simple(att_pkg::opcode_e op, logic [47:0] addr);
    send_item(op, addr, BYTES_W'($urandom), LINE_W'($urandom), FILE_W'($urandom));
  endtask

  // Wait until every owed result has come, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Write tracking_enabled while the block is idle.
  task automatic write_enable(bit en);
    drain();
    cfg_ch.valid            <= 1'b1;
    cfg_ch.tracking_enabled <= en;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.enabled = en;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Address near a few hot buckets so chains grow, with random upper bits.
  function automatic logic [47:0] random_addr();
    logic [47:0] a;
    a = 48'({$urandom, $urandom});
    if ($urandom_range(3) != 0) a[9:0] = 10'($urandom_range(7) * 131);
    return a;
  endfunction

  task automatic random_traffic(int unsigned count, int unsigned hold_at);
    int unsigned pick;
    int unsigned k;
    logic [47:0] a;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == hold_at) hold_left = 400;
      pick = $urandom_range(99);
      if (pick < 45) begin
        a = random_addr();
        live_addrs.push_back(a);
        send_simple(att_pkg::OP_ALLOC, a);
      end else if (pick < 60) begin
        a = random_addr();
        live_addrs.push_back(a);
        send_simple(att_pkg::OP_REALLOC, a);
      end else if (pick < 95) begin
        // Mostly release a known address; sometimes a stray one.
        if (live_addrs.size() != 0 && $urandom_range(4) != 0) begin
          k = $urandom_range(live_addrs.size() - 1);
          a = live_addrs[k];
          live_addrs.delete(k);
        end else begin
          a = random_addr();
        end
        send_simple(att_pkg::OP_FREE, a);
      end else begin
        send_simple(att_pkg::OP_NONE, random_addr());
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    cycles = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = att_pkg::OP_ALLOC;
    in_ch.address = '0;
    in_ch.alloc_size = '0;
    in_ch.source_line = '0;
    in_ch.source_file_id = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.tracking_enabled = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: tracking still off after reset, every opcode is ignored.
    send_simple(att_pkg::OP_ALLOC, 48'h0);
    send_simple(att_pkg::OP_FREE, 48'hFFFF_FFFF_FFFF);
    send_simple(att_pkg::OP_NONE, 48'h3FF);

    write_enable(1'b1);
    send_item(att_pkg::OP_ALLOC, 48'h0, '0, '0, '0);
    send_item(att_pkg::OP_REALLOC, 48'hFFFF_FFFF_FFFF, '1, '1, '1);
    send_item(att_pkg::OP_ALLOC, 48'h0, 31'h2AAA_AAAA, 24'h55_5555, 16'hAAAA);
    send_simple(att_pkg::OP_ALLOC, 48'h400);
    send_simple(att_pkg::OP_FREE, 48'h400);
    send_simple(att_pkg::OP_FREE, 48'h0);
    send_simple(att_pkg::OP_FREE, 48'h0);
    send_simple(att_pkg::OP_FREE, 48'h0);
    send_simple(att_pkg::OP_FREE, 48'h1234_5678_9000);
    send_simple(att_pkg::OP_NONE, 48'hFFFF_FFFF_FFFF);
    send_simple(att_pkg::OP_REALLOC, 48'h8000_0000_0001);
    send_simple(att_pkg::OP_REALLOC, 48'h8000_0000_0001);
    send_simple(att_pkg::OP_FREE, 48'h8000_0000_0001);
    send_simple(att_pkg::OP_FREE, 48'hFFFF_FFFF_FFFF);
    send_simple(att_pkg::OP_FREE, 48'h8000_0000_0001);

    // Random traffic under two of the idling mixes; a hold-off in the first run stalls the block.
    send_idle_pct = 26;
    recv_idle_pct = 56;
    random_traffic(350, 150);
    send_idle_pct = 56;
    recv_idle_pct = 26;
    random_traffic(350, 1000);

    // Switch tracking off: items are ignored and the table is kept.
    write_enable(1'b0);
    for (int i = 0; i < 10; i++) begin
      send_simple(att_pkg::opcode_e'($urandom_range(3)), random_addr());
    end
    write_enable(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(350, 100);

    drain();
    send_simple(att_pkg::OP_ALLOC, 48'h5);
    send_simple(att_pkg::OP_REALLOC, 48'h6);
    send_simple(att_pkg::OP_FREE, 48'h5);
    write_enable(1'b0);
    send_simple(att_pkg::OP_ALLOC, 48'h9);

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
